/* design/composite_video_sync_pixel_generator_assert.svh */
// Assertion macros shared by the checkers of the composite video generator.
// No dependencies; the including module must have clk_i and rst_ni in scope.
`ifndef COMPOSITE_VIDEO_SYNC_PIXEL_GENERATOR_ASSERT_SVH
`define COMPOSITE_VIDEO_SYNC_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define CVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cvs check failed");

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define CVS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cvs check failed");

`endif

/* design/cvs_pkg.sv */
// Shared types and constants of the composite video sync and pixel generator.
// No dependencies.
package cvs_pkg;

  localparam int unsigned POS_W      = 13;
  localparam int unsigned LINE_W     = 9;
  localparam int unsigned PORCH_W    = 10;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned START_W    = 12;
  localparam int unsigned ROW_IDX_W  = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned VSYNC_FIRST = 6;
  localparam int unsigned VSYNC_END   = 12;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_PORCH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HSYNC_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_PORCH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 3'd5;

  // Register values after reset.
  localparam logic [PORCH_W-1:0] RST_FRONT_PORCH = 10'd85;
  localparam logic [PORCH_W-1:0] RST_HSYNC_WIDTH = 10'd170;
  localparam logic [PORCH_W-1:0] RST_BACK_PORCH  = 10'd275;
  localparam logic [POS_W-1:0]   RST_VSYNC_WIDTH = 13'd2850;
  localparam logic [PIX_W-1:0]   RST_PIXEL_WIDTH = 8'd50;
  localparam logic [POS_W-1:0]   RST_LINE_LENGTH = 13'd3040;

  // What the timing unit tells the output stage about one tick.
  typedef struct packed {
    logic              sync_low;
    logic              pix_en;
    logic [LINE_W-1:0] line;
  } tick_info_t;

endpackage

/* design/cvs_div.sv */
// Serial restoring divider, one quotient bit per cycle, for the pixel column resync.
// Depends on cvs_pkg.
module cvs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cvs_pkg::POS_W-1:0]  dividend_i,
  input  logic [cvs_pkg::PIX_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [cvs_pkg::POS_W-1:0]  quotient_o,
  output logic [cvs_pkg::PIX_W-1:0]  remainder_o
);
  import cvs_pkg::*;

  localparam int unsigned STEP_W = $clog2(POS_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(POS_W - 1);

  logic              run_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [POS_W-1:0]  dvd_q;
  logic [PIX_W-1:0]  rem_q, dvs_q;
  logic [PIX_W:0]    trial, diff;
  logic              fits;

  assign trial = {rem_q, dvd_q[POS_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in from the bottom as the dividend shifts out the top.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[POS_W-2:0], fits};
      rem_q <= fits ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
    end
  end

  assign busy_o      = run_q | done_q;
  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

/* design/cvs_timing.sv */
// Line and position counters, timing registers and pixel column tracking.
// Depends on cvs_pkg and cvs_div.
module cvs_timing #(
  parameter int unsigned FRAME_LINES        = 262,
  parameter int unsigned PICTURE_ROWS       = 23,
  parameter int unsigned PICTURE_COLS       = 28,
  parameter int unsigned LINES_PER_ROW      = 10,
  parameter int unsigned FIRST_PICTURE_LINE = 30,
  parameter int unsigned ROW_AW = (PICTURE_ROWS > 1) ? $clog2(PICTURE_ROWS) : 1,
  parameter int unsigned COL_W  = $clog2(PICTURE_COLS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cvs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cvs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            tick_i,
  output logic                            busy_o,
  output cvs_pkg::tick_info_t             info_o,
  output logic [COL_W-1:0]                col_o,
  output logic [ROW_AW-1:0]               rd_row_o
);
  import cvs_pkg::*;

  localparam int unsigned LINE_CW = LINE_W + 1;
  localparam logic [LINE_W-1:0] FIRST_C   = LINE_W'(FIRST_PICTURE_LINE);
  localparam logic [COL_W-1:0]  COLS_C    = COL_W'(PICTURE_COLS);
  localparam logic [POS_W-1:0]  COLS_Q_C  = POS_W'(PICTURE_COLS);
  // Reciprocal of the lines per row, scaled so any 9-bit line offset divides exactly.
  localparam int unsigned ROW_SH = 15;
  localparam int unsigned ROW_PW = LINE_W + ROW_SH + 1;
  localparam logic [ROW_PW-1:0] ROW_RECIP_C =
    ROW_PW'(((1 << ROW_SH) + LINES_PER_ROW - 1) / LINES_PER_ROW);

  logic [PORCH_W-1:0] fp_q, hs_q, bp_q;
  logic [POS_W-1:0]   vs_q, ll_q;
  logic [PIX_W-1:0]   pw_q;
  logic               cfg_pend_q;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [PIX_W-1:0]  sub_q, sub_d;

  logic [START_W-1:0] start, hs_end;
  logic [POS_W-1:0]   start_p;
  logic               vsync_line, sync, pos_ge_start, pix_en;
  logic [LINE_CW-1:0] line_inc;
  logic [LINE_W-1:0]  next_line, row_full, line_off;
  logic [ROW_PW-1:0]  row_prod;
  logic               row_ok;
  logic [POS_W:0]     pos_inc;
  logic               wrap;
  logic [POS_W-1:0]   pos_nx;
  logic [PIX_W:0]     sub_inc;
  logic               sub_wrap;

  logic               div_busy, div_done;
  logic [POS_W-1:0]   div_quo, div_dvd;
  logic [PIX_W-1:0]   div_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q       <= RST_FRONT_PORCH;
      hs_q       <= RST_HSYNC_WIDTH;
      bp_q       <= RST_BACK_PORCH;
      vs_q       <= RST_VSYNC_WIDTH;
      pw_q       <= RST_PIXEL_WIDTH;
      ll_q       <= RST_LINE_LENGTH;
      cfg_pend_q <= 1'b0;
    end else begin
      cfg_pend_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FRONT_PORCH: fp_q <= cfg_data_i[PORCH_W-1:0];
          CFG_HSYNC_WIDTH: hs_q <= cfg_data_i[PORCH_W-1:0];
          CFG_BACK_PORCH:  bp_q <= cfg_data_i[PORCH_W-1:0];
          CFG_VSYNC_WIDTH: vs_q <= cfg_data_i[POS_W-1:0];
          CFG_PIXEL_WIDTH: pw_q <= cfg_data_i[PIX_W-1:0];
          CFG_LINE_LENGTH: ll_q <= cfg_data_i[POS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign hs_end  = START_W'(fp_q) + START_W'(hs_q);
  assign start   = hs_end + START_W'(bp_q);
  assign start_p = POS_W'(start);

  assign vsync_line = (line_q >= LINE_W'(VSYNC_FIRST)) && (line_q < LINE_W'(VSYNC_END));
  assign sync = vsync_line ? (pos_q < vs_q)
                           : ((pos_q >= POS_W'(fp_q)) && (pos_q < POS_W'(hs_end)));

  // Picture lines draw the row of the following line.
  assign line_inc  = {1'b0, line_q} + 1'b1;
  assign next_line = (line_inc >= LINE_CW'(FRAME_LINES)) ? '0 : line_inc[LINE_W-1:0];
  assign line_off  = next_line - FIRST_C;
  assign row_prod  = ROW_PW'(line_off) * ROW_RECIP_C;
  assign row_full  = row_prod[ROW_SH +: LINE_W];
  assign row_ok    = (next_line >= FIRST_C) && (row_full < LINE_W'(PICTURE_ROWS));
  assign rd_row_o  = row_ok ? row_full[ROW_AW-1:0] : '0;

  assign pos_ge_start = pos_q >= start_p;
  assign pix_en = !vsync_line && row_ok && (pw_q != '0) && pos_ge_start && (col_q < COLS_C);

  assign info_o = '{sync_low: sync, pix_en: pix_en, line: line_q};
  assign col_o  = col_q;

  assign pos_inc  = {1'b0, pos_q} + 1'b1;
  assign wrap     = pos_inc >= {1'b0, ll_q};
  assign pos_nx   = wrap ? '0 : pos_inc[POS_W-1:0];
  assign sub_inc  = {1'b0, sub_q} + 1'b1;
  assign sub_wrap = sub_inc == {1'b0, pw_q};

  // Column and offset inside the pixel follow the position; a config write
  // reloads them from the divider.
  always_comb begin
    pos_d  = pos_q;
    line_d = line_q;
    col_d  = col_q;
    sub_d  = sub_q;
    if (div_done) begin
      col_d = (div_quo >= COLS_Q_C) ? COLS_C : div_quo[COL_W-1:0];
      sub_d = div_rem;
    end else if (tick_i) begin
      pos_d  = pos_nx;
      line_d = wrap ? next_line : line_q;
      if (pos_nx == start_p) begin
        col_d = '0;
        sub_d = '0;
      end else if (pos_nx > start_p) begin
        if (sub_wrap) begin
          sub_d = '0;
          col_d = (col_q < COLS_C) ? col_q + 1'b1 : col_q;
        end else begin
          sub_d = sub_inc[PIX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      line_q <= '0;
      col_q  <= '0;
      sub_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      line_q <= line_d;
      col_q  <= col_d;
      sub_q  <= sub_d;
    end
  end

  assign div_dvd = pos_ge_start ? (pos_q - start_p) : '0;

  cvs_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cfg_pend_q),
    .dividend_i  (div_dvd),
    .divisor_i   (pw_q),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign busy_o = cfg_pend_q | div_busy;

endmodule

/* design/cvs_store.sv */
// Picture store: one synchronous memory row per picture row, registered read.
// Rows never written read as black through per-row valid bits. Depends on cvs_pkg.
module cvs_store #(
  parameter int unsigned PICTURE_ROWS = 23,
  parameter int unsigned PICTURE_COLS = 28,
  parameter int unsigned ROW_AW = (PICTURE_ROWS > 1) ? $clog2(PICTURE_ROWS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [ROW_AW-1:0]       wr_addr_i,
  input  logic [PICTURE_COLS-1:0] wr_data_i,
  input  logic                    rd_en_i,
  input  logic [ROW_AW-1:0]       rd_addr_i,
  output logic [PICTURE_COLS-1:0] rd_data_o
);
  import cvs_pkg::*;

  logic [PICTURE_COLS-1:0] mem_q [PICTURE_ROWS];
  logic [PICTURE_ROWS-1:0] valid_q;
  logic [PICTURE_COLS-1:0] rd_data_q;
  logic                    rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* design/composite_video_sync_pixel_generator.sv */
// Composite video sync and pixel generator, top level.
// A tick item's result passes through the store read and then the output register.
// Throughput: one item per cycle while the input is not stalled; a write item gives no result.
// After each configuration write the input stalls while a serial divider recomputes
// the pixel column. Reset (async, active low) clears counters, restores default timing
// and marks every picture row black.
module composite_video_sync_pixel_generator #(
  parameter int unsigned FRAME_LINES        = 262,
  parameter int unsigned PICTURE_ROWS       = 23,
  parameter int unsigned PICTURE_COLS       = 28,
  parameter int unsigned LINES_PER_ROW      = 10,
  parameter int unsigned FIRST_PICTURE_LINE = 30
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cvs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cvs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [cvs_pkg::ROW_IDX_W-1:0]   row_index_i,
  input  logic [PICTURE_COLS-1:0]         row_bits_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            sync_low_o,
  output logic                            video_white_o,
  output logic [cvs_pkg::LINE_W-1:0]      line_number_o
);
  import cvs_pkg::*;

  localparam int unsigned ROW_AW = (PICTURE_ROWS > 1) ? $clog2(PICTURE_ROWS) : 1;
  localparam int unsigned COL_W  = $clog2(PICTURE_COLS + 1);
  localparam int unsigned COL_IW = (PICTURE_COLS > 1) ? $clog2(PICTURE_COLS) : 1;
  localparam int unsigned RIX_W  = 7;

  logic               busy, accept, tick_acc, wr_acc, wr_ok, s1_adv;
  tick_info_t         info, s1_info_q;
  logic [COL_W-1:0]   col, s1_col_q;
  logic [ROW_AW-1:0]  rd_row;
  logic [PICTURE_COLS-1:0] rd_data;
  logic               s1_valid_q;
  logic               out_valid_q, sync_q, video_q;
  logic [LINE_W-1:0]  line_q;

  assign cfg_ready_o = !busy;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;
  assign tick_acc   = accept && !req_type_i;
  assign wr_acc     = accept && req_type_i;
  // Drop writes to rows the store does not have.
  assign wr_ok      = RIX_W'(row_index_i) < RIX_W'(PICTURE_ROWS);

  cvs_timing #(
    .FRAME_LINES        (FRAME_LINES),
    .PICTURE_ROWS       (PICTURE_ROWS),
    .PICTURE_COLS       (PICTURE_COLS),
    .LINES_PER_ROW      (LINES_PER_ROW),
    .FIRST_PICTURE_LINE (FIRST_PICTURE_LINE),
    .ROW_AW             (ROW_AW),
    .COL_W              (COL_W)
  ) u_timing (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tick_i      (tick_acc),
    .busy_o      (busy),
    .info_o      (info),
    .col_o       (col),
    .rd_row_o    (rd_row)
  );

  cvs_store #(
    .PICTURE_ROWS (PICTURE_ROWS),
    .PICTURE_COLS (PICTURE_COLS),
    .ROW_AW       (ROW_AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_acc && wr_ok),
    .wr_addr_i (ROW_AW'(row_index_i)),
    .wr_data_i (row_bits_i),
    .rd_en_i   (tick_acc),
    .rd_addr_i (rd_row),
    .rd_data_o (rd_data)
  );

  // Stage 1 waits for the store read; the output register behind it lets a
  // new item in while a result is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_info_q <= info;
      s1_col_q  <= col;
    end
    if (s1_adv && s1_valid_q) begin
      sync_q  <= s1_info_q.sync_low;
      video_q <= s1_info_q.pix_en & rd_data[s1_col_q[COL_IW-1:0]];
      line_q  <= s1_info_q.line;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sync_low_o    = sync_q;
  assign video_white_o = video_q;
  assign line_number_o = line_q;

endmodule

/* design/cvs_checker.sv */
// Port-level checks of the composite video generator, bound to the top level.
// Depends on cvs_pkg and composite_video_sync_pixel_generator_assert.svh.
`include "composite_video_sync_pixel_generator_assert.svh"

module cvs_checker #(
  parameter int unsigned FRAME_LINES = 262
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_ready_o,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        sync_low_o,
  input logic                        video_white_o,
  input logic [cvs_pkg::LINE_W-1:0]  line_number_o
);
  import cvs_pkg::*;

  logic vsync_line;
  assign vsync_line = (line_number_o >= LINE_W'(VSYNC_FIRST)) &&
                      (line_number_o < LINE_W'(VSYNC_END));

  // A stalled result holds.
  `CVS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(sync_low_o) && $stable(video_white_o) && $stable(line_number_o))
  // Sync pulses and picture never overlap.
  `CVS_ASSERT_IMP(a_sync_video_excl, out_valid_o, !(sync_low_o && video_white_o))
  `CVS_ASSERT_IMP(a_line_range, out_valid_o, line_number_o < LINE_W'(FRAME_LINES))
  `CVS_ASSERT_IMP(a_vsync_black, out_valid_o && vsync_line, !video_white_o)
  // While the column resync runs, no item may enter.
  `CVS_ASSERT_IMP(a_busy_stalls, !cfg_ready_o, in_stall_o)

endmodule

bind composite_video_sync_pixel_generator cvs_checker #(
  .FRAME_LINES (FRAME_LINES)
) u_cvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_ready_o   (cfg_ready_o),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .sync_low_o    (sync_low_o),
  .video_white_o (video_white_o),
  .line_number_o (line_number_o)
);

/* dv/tb_composite_video_sync_pixel_generator.sv */
// Self-checking testbench for composite_video_sync_pixel_generator.
// Needs cvs_pkg and the block's RTL; tick and row-write items are driven, every
// output sample is checked against a cycle-free model of the beam and picture store.
module tb_composite_video_sync_pixel_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import cvs_pkg::*;

  localparam int unsigned FRAME_LINES        = 262;
  localparam int unsigned PICTURE_ROWS       = 23;
  localparam int unsigned PICTURE_COLS       = 28;
  localparam int unsigned LINES_PER_ROW      = 10;
  localparam int unsigned FIRST_PICTURE_LINE = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE_TICKS = 6;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum logic {
    REQ_TICK      = 1'b0,
    REQ_ROW_WRITE = 1'b1
  } req_kind_e;

  typedef struct {
    req_kind_e               kind;
    logic [ROW_IDX_W-1:0]    row;
    logic [PICTURE_COLS-1:0] bits;
  } scan_req_t;

  typedef struct packed {
    logic              sync;
    logic              white;
    logic [LINE_W-1:0] line;
  } scan_sample_t;

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic                    req_type_i    = 1'b0;
  logic [ROW_IDX_W-1:0]    row_index_i   = '0;
  logic [PICTURE_COLS-1:0] row_bits_i    = '0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic                    sync_low_o;
  logic                    video_white_o;
  logic [LINE_W-1:0]       line_number_o;

  composite_video_sync_pixel_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .row_index_i  (row_index_i),
    .row_bits_i   (row_bits_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sync_low_o   (sync_low_o),
    .video_white_o(video_white_o),
    .line_number_o(line_number_o)
  );

  // Beam model state and its copy of the timing registers.
  logic [PORCH_W-1:0]      front_porch_q = RST_FRONT_PORCH;
  logic [PORCH_W-1:0]      hsync_width_q = RST_HSYNC_WIDTH;
  logic [PORCH_W-1:0]      back_porch_q  = RST_BACK_PORCH;
  logic [POS_W-1:0]        vsync_width_q = RST_VSYNC_WIDTH;
  logic [PIX_W-1:0]        pixel_width_q = RST_PIXEL_WIDTH;
  logic [POS_W-1:0]        line_length_q = RST_LINE_LENGTH;
  logic [LINE_W-1:0]       beam_line     = '0;
  logic [POS_W-1:0]        beam_pos      = '0;
  logic [PICTURE_COLS-1:0] picture_rows [PICTURE_ROWS];

  scan_req_t    req_q[$];
  scan_sample_t scan_q[$];
  scan_req_t    cur_req;
  int unsigned  n_req_queued  = 0;
  int unsigned  n_req_taken   = 0;
  int unsigned  n_mismatch    = 0;
  int unsigned  idle_cycles   = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  initial begin
    foreach (picture_rows[r]) picture_rows[r] = '0;
  end

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one accepted item to the beam model; a tick queues its expected sample.
  function automatic void beam_step(input scan_req_t req);
    int unsigned  pos;
    int unsigned  ln;
    int unsigned  next_line;
    int unsigned  start;
    int unsigned  row;
    int unsigned  col;
    scan_sample_t s;
    pos = beam_pos;
    ln  = beam_line;
    if (req.kind == REQ_ROW_WRITE) begin
      if (req.row < PICTURE_ROWS) picture_rows[req.row] = req.bits;
      return;
    end
    s.line  = ln[LINE_W-1:0];
    s.white = 1'b0;
    if (ln >= VSYNC_FIRST && ln < VSYNC_END) begin
      s.sync = (pos < vsync_width_q);
    end else begin
      s.sync = (pos >= front_porch_q) && (pos < front_porch_q + hsync_width_q);
      // Pixels come from the row of the line that follows.
      next_line = (ln + 1 >= FRAME_LINES) ? 0 : ln + 1;
      start     = front_porch_q + hsync_width_q + back_porch_q;
      if (next_line >= FIRST_PICTURE_LINE && pixel_width_q != 0 && pos >= start) begin
        row = (next_line - FIRST_PICTURE_LINE) / LINES_PER_ROW;
        col = (pos - start) / pixel_width_q;
        if (row < PICTURE_ROWS && col < PICTURE_COLS) s.white = picture_rows[row][col];
      end
    end
    scan_q.push_back(s);
    pos = pos + 1;
    if (pos >= line_length_q) begin
      pos = 0;
      ln  = (ln + 1 >= FRAME_LINES) ? 0 : ln + 1;
    end
    beam_pos  = pos[POS_W-1:0];
    beam_line = ln[LINE_W-1:0];
  endfunction

  function automatic void flag_mismatch(input string msg);
    if (n_mismatch < MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
    n_mismatch++;
  endfunction

  function automatic void queue_req(input req_kind_e kind, input logic [ROW_IDX_W-1:0] row,
                                    input logic [PICTURE_COLS-1:0] bits);
    scan_req_t r;
    r.kind = kind;
    r.row  = row;
    r.bits = bits;
    req_q.push_back(r);
    n_req_queued++;
  endfunction

  // Item driver: hold while stalled, otherwise present the next item or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        beam_step(cur_req);
        n_req_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_req = req_q.pop_front();
          in_valid_i  <= 1'b1;
          req_type_i  <= cur_req.kind;
          row_index_i <= cur_req.row;
          row_bits_i  <= cur_req.bits;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Sample monitor: check every accepted output sample against the oldest expected one.
  always @(posedge clk_i) begin
    scan_sample_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (scan_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected sample sync=%0b white=%0b line=%0d",
                                  sync_low_o, video_white_o, line_number_o));
        end else begin
          want = scan_q.pop_front();
          if (sync_low_o !== want.sync)
            flag_mismatch($sformatf("sync_low exp %0b got %0b (line %0d)",
                                    want.sync, sync_low_o, want.line));
          if (video_white_o !== want.white)
            flag_mismatch($sformatf("video_white exp %0b got %0b (line %0d)",
                                    want.white, video_white_o, want.line));
          if (line_number_o !== want.line)
            flag_mismatch($sformatf("line_number exp %0d got %0d",
                                    want.line, line_number_o));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: end the run when no channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic program_timing_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FRONT_PORCH: front_porch_q = data[PORCH_W-1:0];
      CFG_HSYNC_WIDTH: hsync_width_q = data[PORCH_W-1:0];
      CFG_BACK_PORCH:  back_porch_q  = data[PORCH_W-1:0];
      CFG_VSYNC_WIDTH: vsync_width_q = data[POS_W-1:0];
      CFG_PIXEL_WIDTH: pixel_width_q = data[PIX_W-1:0];
      CFG_LINE_LENGTH: line_length_q = data[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_timing(input int unsigned fp, input int unsigned hs,
                                input int unsigned bp, input int unsigned vs,
                                input int unsigned pw, input int unsigned ll);
    program_timing_reg(CFG_FRONT_PORCH, fp[CFG_DATA_W-1:0]);
    program_timing_reg(CFG_HSYNC_WIDTH, hs[CFG_DATA_W-1:0]);
    program_timing_reg(CFG_BACK_PORCH,  bp[CFG_DATA_W-1:0]);
    program_timing_reg(CFG_VSYNC_WIDTH, vs[CFG_DATA_W-1:0]);
    program_timing_reg(CFG_PIXEL_WIDTH, pw[CFG_DATA_W-1:0]);
    program_timing_reg(CFG_LINE_LENGTH, ll[CFG_DATA_W-1:0]);
  endtask

  // Wait until every item is taken and every sample is back, then let writes settle.
  task automatic wait_drained();
    do @(posedge clk_i); while (n_req_taken != n_req_queued || scan_q.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic set_idle_mode(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      1: begin send_idle_pct = 57; recv_idle_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_idle_pct = 57; end
      default: begin send_idle_pct = 12; recv_idle_pct = 12; end
    endcase
  endtask

  initial begin
    req_kind_e kind;
    logic [ROW_IDX_W-1:0] row;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idle_mode(0);

    // Fill rows at the extremes, hit the ignored rows, then sample the reset timing.
    queue_req(REQ_ROW_WRITE, 5'd0,  28'hFFFFFFF);
    queue_req(REQ_ROW_WRITE, 5'd22, 28'hAAAAAAA);
    queue_req(REQ_ROW_WRITE, 5'd31, 28'hFFFFFFF);
    queue_req(REQ_ROW_WRITE, 5'd23, 28'h5555555);
    queue_req(REQ_ROW_WRITE, 5'd1,  28'h0000000);
    repeat (4) queue_req(REQ_TICK, 5'd0, '0);
    wait_drained();

    // One tick per line: walk through the vertical sync lines.
    program_timing(0, 1, 0, 1, 1, 1);
    repeat (16) queue_req(REQ_TICK, 5'd31, 28'hFFFFFFF);
    wait_drained();

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: program_timing(0, 1, 0, 2, 1, 3);
        1: program_timing(1, 2, 1, 8191, 1, 33);
        2: program_timing(1023, 1023, 1023, 0, 255, 8191);
        // Shrink the line below the current position.
        3: program_timing(2, 3, 0, 5, 2, 6);
        // Zero pixel width, zero line length and unused register indexes.
        4: begin
          program_timing(0, 1, 0, 1, 0, 0);
          program_timing_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 8191)));
          program_timing_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 8191)));
        end
        default: program_timing($urandom_range(0, 3), $urandom_range(0, 4),
                                $urandom_range(0, 3), $urandom_range(0, 40),
                                $urandom_range(1, 2), $urandom_range(1, 40));
      endcase
      set_idle_mode(ph % 4);
      repeat (PHASE_ITEMS) begin
        kind = ($urandom_range(0, 99) < 20) ? REQ_ROW_WRITE : REQ_TICK;
        if (kind == REQ_ROW_WRITE && $urandom_range(0, 9) != 0)
          row = ROW_IDX_W'($urandom_range(0, PICTURE_ROWS - 1));
        else
          row = ROW_IDX_W'($urandom_range(0, 31));
        queue_req(kind, row, PICTURE_COLS'($urandom()));
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (n_mismatch == 0 && scan_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/cvs_pkg.sv
design/cvs_div.sv
design/cvs_timing.sv
design/cvs_store.sv
design/composite_video_sync_pixel_generator.sv
design/cvs_checker.sv
dv/tb_composite_video_sync_pixel_generator.sv
